// ===== rtl/middle_removal_bag_assert.svh =====
// Assertion macros used by the middle removal bag RTL.
`ifndef MIDDLE_REMOVAL_BAG_ASSERT_SVH
`define MIDDLE_REMOVAL_BAG_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MRB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrb assertion failed");

// Next-cycle implication, checked out of reset.
`define MRB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrb assertion failed");

`endif

// ===== rtl/mrb_pkg.sv =====
// Types and constants for the middle removal bag.
`timescale 1ns / 1ps
package mrb_pkg;

  localparam int DEPTH_DEF = 16;

  // request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // cell source select codes
  localparam logic [1:0] SEL_HOLD = 2'd0;
  localparam logic [1:0] SEL_LO   = 2'd1;
  localparam logic [1:0] SEL_HI   = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] push_value;
  } mrb_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         item_total;
    logic               is_empty;
    logic signed [31:0] middle_value;
    logic               middle_valid;
  } mrb_out_t;

  typedef struct packed {
    logic [1:0] sel;
    logic       load;
  } cell_ctl_t;

endpackage

// ===== rtl/mrb_cell.sv =====
// One storage cell of the bag: holds an item, takes a neighbor or a new item.
`timescale 1ns / 1ps
module mrb_cell (
  input  logic                      clk,
  input  mrb_pkg::cell_ctl_t        ctl,
  input  logic signed [31:0]        from_lo,
  input  logic signed [31:0]        from_hi,
  input  logic signed [31:0]        ext_value,
  output logic signed [31:0]        value_nxt,
  output logic signed [31:0]        value
);
  import mrb_pkg::*;

  logic signed [31:0] value_r;

  // pick the next item: a new item wins over a neighbor transfer
  always_comb begin
    if (ctl.load) begin
      value_nxt = ext_value;
    end else begin
      case (ctl.sel)
        SEL_LO:   value_nxt = from_lo;
        SEL_HI:   value_nxt = from_hi;
        SEL_HOLD: value_nxt = value_r;
        default:  value_nxt = value_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// ===== rtl/middle_removal_bag.sv =====
// Middle removal bag: top level with the two cell chains around the middle item.
// Each result is registered and becomes valid in the cycle after its input transfer.
// Throughput: one operation per cycle while in_stall is low; every cell moves by at most one place per op.
// The middle item always sits in the first cell of the lower chain, so no search is needed.
// Reset clears the item count and the result valid; cell contents are not reset.
`timescale 1ns / 1ps
module middle_removal_bag #(
  parameter int DEPTH = mrb_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mrb_pkg::mrb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mrb_pkg::mrb_out_t out_data
);
  import mrb_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  // lower chain: item at middle down to item 0; upper chain: middle+1 upward
  localparam int LH = (DEPTH + 1) / 2;
  localparam int RH = DEPTH / 2;

  logic [CW-1:0]      cnt_r, cnt_nxt, mid;
  logic               out_valid_r;
  mrb_out_t           out_data_r;
  logic               in_xfer, is_push, full, empty, odd;
  logic               do_push, do_pop, mid_up;
  logic [1:0]         status;
  logic [CW+4:0]      tot_ext;

  logic signed [31:0] l_val [LH];
  logic signed [31:0] l_nxt [LH];
  logic signed [31:0] r_val [RH];
  logic signed [31:0] r_nxt [RH];
  cell_ctl_t          l_ctl [LH];
  cell_ctl_t          r_ctl [RH];

  // handshake: the output register parts the two sides
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  assign is_push = (in_data.req_type == REQ_PUSH);
  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign odd     = cnt_r[0];
  assign mid     = (cnt_r - CW'(1)) >> 1;
  assign do_push = in_xfer && is_push && !full;
  assign do_pop  = in_xfer && !is_push && !empty;
  // push on an even nonzero count moves the middle one item up
  assign mid_up  = do_push && !odd && !empty;

  // lower chain
  for (genvar i = 0; i < LH; i++) begin : g_lo
    logic signed [31:0] lo_src, hi_src;

    assign lo_src = (i == 0) ? r_val[0] : l_val[(i == 0) ? 0 : i - 1];
    assign hi_src = (i == LH - 1) ? l_val[i] : l_val[(i == LH - 1) ? i : i + 1];

    always_comb begin
      l_ctl[i].sel  = SEL_HOLD;
      l_ctl[i].load = do_push && empty && (i == 0);
      if (mid_up) begin
        l_ctl[i].sel = SEL_LO;
      end else if (do_pop && odd) begin
        l_ctl[i].sel = SEL_HI;
      end else if (do_pop && !odd && (i == 0)) begin
        l_ctl[i].sel = SEL_LO;
      end
    end

    mrb_cell u_cell (
      .clk       (clk),
      .ctl       (l_ctl[i]),
      .from_lo   (lo_src),
      .from_hi   (hi_src),
      .ext_value (in_data.push_value),
      .value_nxt (l_nxt[i]),
      .value     (l_val[i])
    );
  end

  // upper chain
  for (genvar i = 0; i < RH; i++) begin : g_hi
    logic signed [31:0] hi_src;

    assign hi_src = (i == RH - 1) ? r_val[i] : r_val[(i == RH - 1) ? i : i + 1];

    always_comb begin
      r_ctl[i].sel  = (mid_up || (do_pop && !odd)) ? SEL_HI : SEL_HOLD;
      r_ctl[i].load = do_push && !empty && (mid == CW'(i));
    end

    mrb_cell u_cell (
      .clk       (clk),
      .ctl       (r_ctl[i]),
      .from_lo   (r_val[i]),
      .from_hi   (hi_src),
      .ext_value (in_data.push_value),
      .value_nxt (r_nxt[i]),
      .value     (r_val[i])
    );
  end

  // count and status
  always_comb begin
    cnt_nxt = cnt_r;
    status  = STAT_OK;
    if (do_push) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    if (in_xfer && is_push && full) begin
      status = STAT_FULL;
    end else if (in_xfer && !is_push && empty) begin
      status = STAT_EMPTY;
    end
  end

  assign tot_ext = {5'b0, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // capture the result of each transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r.status       <= status;
      out_data_r.item_total   <= tot_ext[4:0];
      out_data_r.is_empty     <= (cnt_nxt == '0);
      out_data_r.middle_value <= (cnt_nxt != '0) ? l_nxt[0] : 32'sd0;
      out_data_r.middle_valid <= (cnt_nxt != '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "middle_removal_bag_assert.svh"

  `MRB_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CW'(DEPTH))
  `MRB_ASSERT_NXT(a_full_keeps_cnt, in_xfer && is_push && full, cnt_r == $past(cnt_r))
  `MRB_ASSERT_NXT(a_xfer_gives_result, in_xfer, out_valid_r)
  `MRB_ASSERT_IMP(a_mid_flag, out_valid_r, out_data_r.middle_valid == !out_data_r.is_empty)
  // upper cells hold still when nothing is transferred
  `MRB_ASSERT_IMP(a_hi_idle_hold, !in_xfer, r_nxt[0] === r_val[0])

endmodule
